// ----- sv/cct_pkg.sv -----
// Shared constants and codes for the codec command/response tracker.
`default_nettype none

package cct_pkg;

  localparam int RING_ENTRIES = 256;
  localparam int UNSOL_DEPTH  = 64;
  localparam int CODEC_LIMIT  = 8;

  localparam int NUM_CODECS   = 16;
  localparam int CODEC_SHIFT  = 28;
  localparam int UNSOL_BIT    = 4;
  localparam int ENTRY_W      = 64;

  localparam logic [8:0] COUNT_MAX = 9'd511;

  localparam logic [1:0] OP_SEND   = 2'd0;
  localparam logic [1:0] OP_RESP   = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  localparam logic [3:0] ST_SENT      = 4'd0;
  localparam logic [3:0] ST_FULL      = 4'd1;
  localparam logic [3:0] ST_BAD_CODEC = 4'd2;
  localparam logic [3:0] ST_UNSOL     = 4'd3;
  localparam logic [3:0] ST_MATCHED   = 4'd4;
  localparam logic [3:0] ST_SPURIOUS  = 4'd5;
  localparam logic [3:0] ST_POPPED    = 4'd6;
  localparam logic [3:0] ST_EMPTY     = 4'd7;
  localparam logic [3:0] ST_CANCELLED = 4'd8;

endpackage

`default_nettype wire

// ----- sv/codec_command_response_tracker_top.sv -----
// Top level of the codec command/response tracker.
//
//   channel  direction  ports
//   in_      request    in_valid/in_ready, in_op, in_command, in_ring_read_pointer,
//                       in_response_word, in_response_extra
//   out_     result     out_valid/out_ready, out_status, out_ring_slot, out_codec,
//                       out_pending_slot, out_data, out_popped_extra, out_queue_overflow
//
// One request a cycle sustained while out_ready is held; an accepted request is loaded into
// the input register and then into the result register, which drives out_valid.
// The unsolicited queue RAM is read ahead, at the entry the next pop takes, with a write bypass.
// Synchronous active-low reset clears pointers, indices and pending counts.
// A stalled result holds the request in the input register and blocks new input.
`default_nettype none

module codec_command_response_tracker_top
  import cct_pkg::*;
#(
  parameter int UNSOL_DEPTH_P = UNSOL_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_command,
  input  wire logic [7:0]  in_ring_read_pointer,
  input  wire logic [31:0] in_response_word,
  input  wire logic [31:0] in_response_extra,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_status,
  output logic [7:0]       out_ring_slot,
  output logic [3:0]       out_codec,
  output logic [7:0]       out_pending_slot,
  output logic [31:0]      out_data,
  output logic [31:0]      out_popped_extra,
  output logic             out_queue_overflow
);

  localparam int UW = $clog2(UNSOL_DEPTH_P);
  localparam logic [UW-1:0] U_LAST = UW'(UNSOL_DEPTH_P - 1);
  localparam logic [7:0] RING_LAST = 8'(RING_ENTRIES - 1);
  localparam logic [4:0] LIMIT = 5'(CODEC_LIMIT);

  // input register
  logic        in_v_r;
  logic [1:0]  op_r;
  logic [31:0] cmd_r;
  logic [7:0]  rdp_r;
  logic [31:0] resp_r;
  logic [31:0] ext_r;

  // state
  logic [7:0]    wp_r;
  logic [8:0]    pcnt_r [NUM_CODECS];
  logic [7:0]    pmod_r [NUM_CODECS];
  logic [UW-1:0] rd_r;
  logic [UW-1:0] wr_r;

  // result register
  logic        out_v_r;
  logic [3:0]  status_r;
  logic [7:0]  slot_r;
  logic [3:0]  codec_r;
  logic [7:0]  pslot_r;
  logic [31:0] data_r;
  logic [31:0] pextra_r;
  logic        ovf_r;

  logic adv;

  // combinational results
  logic [3:0]  status_c;
  logic [7:0]  slot_c;
  logic [3:0]  codec_c;
  logic [7:0]  pslot_c;
  logic [31:0] data_c;
  logic [31:0] pextra_c;
  logic        ovf_c;

  logic [7:0]    wp_inc;
  logic [7:0]    wp_calc;
  logic [3:0]    cmd_codec;
  logic [3:0]    pidx;
  logic [8:0]    pcnt_cur;
  logic [7:0]    pmod_cur;
  logic [7:0]    pmod_up;
  logic [7:0]    pmod_dn;
  logic          pwe;
  logic [8:0]    pcnt_new;
  logic [7:0]    pmod_new;
  logic [UW-1:0] rd_calc;
  logic [UW-1:0] wr_calc;
  logic [UW-1:0] rd_next;
  logic [UW-1:0] wr_inc;
  logic [UW-1:0] rd_inc;
  logic [UW-1:0] raddr;
  logic          push;
  logic          ram_we;

  logic [ENTRY_W-1:0] ram_q;
  logic [ENTRY_W-1:0] byp_data_r;
  logic               byp_hit_r;
  logic [ENTRY_W-1:0] q_entry;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  assign cmd_codec = cmd_r[CODEC_SHIFT +: 4];
  assign pidx      = (op_r == OP_RESP) ? ext_r[3:0] : cmd_codec;
  assign pcnt_cur  = pcnt_r[pidx];
  assign pmod_cur  = pmod_r[pidx];
  assign pmod_up   = (pmod_cur == RING_LAST) ? 8'd0 : pmod_cur + 8'd1;
  assign pmod_dn   = (pmod_cur == 8'd0) ? RING_LAST : pmod_cur - 8'd1;
  assign wp_inc    = (wp_r == RING_LAST) ? 8'd0 : wp_r + 8'd1;
  assign wr_inc    = (wr_r == U_LAST) ? '0 : wr_r + UW'(1);
  assign rd_inc    = (rd_r == U_LAST) ? '0 : rd_r + UW'(1);
  assign q_entry   = byp_hit_r ? byp_data_r : ram_q;

  always_comb begin
    status_c = ST_SENT;
    slot_c   = '0;
    codec_c  = '0;
    pslot_c  = '0;
    data_c   = '0;
    pextra_c = '0;
    ovf_c    = 1'b0;
    wp_calc  = wp_r;
    rd_calc  = rd_r;
    wr_calc  = wr_r;
    pwe      = 1'b0;
    pcnt_new = pcnt_cur;
    pmod_new = pmod_cur;
    push     = 1'b0;
    case (op_r)
      OP_SEND: begin
        codec_c = cmd_codec;
        if (wp_inc == rdp_r) begin
          status_c = ST_FULL;
        end else begin
          status_c = ST_SENT;
          pslot_c  = pmod_cur;
          if (pcnt_cur != COUNT_MAX) begin
            pwe      = 1'b1;
            pcnt_new = pcnt_cur + 9'd1;
            pmod_new = pmod_up;
          end
          wp_calc = wp_inc;
          slot_c  = wp_inc;
          data_c  = cmd_r;
        end
      end
      OP_RESP: begin
        codec_c = ext_r[3:0];
        if ({1'b0, ext_r[3:0]} >= LIMIT) begin
          status_c = ST_BAD_CODEC;
        end else if (ext_r[UNSOL_BIT]) begin
          status_c = ST_UNSOL;
          push     = 1'b1;
          wr_calc  = wr_inc;
          ovf_c    = (wr_inc == rd_r);
        end else if (pcnt_cur != 9'd0) begin
          status_c = ST_MATCHED;
          pwe      = 1'b1;
          pcnt_new = pcnt_cur - 9'd1;
          pmod_new = pmod_dn;
          pslot_c  = pmod_dn;
          data_c   = resp_r;
        end else begin
          status_c = ST_SPURIOUS;
        end
      end
      OP_CANCEL: begin
        codec_c  = cmd_codec;
        status_c = ST_CANCELLED;
        if (pcnt_cur != 9'd0) begin
          pwe      = 1'b1;
          pcnt_new = pcnt_cur - 9'd1;
          pmod_new = pmod_dn;
        end
      end
      OP_POP: begin
        if (rd_r == wr_r) begin
          status_c = ST_EMPTY;
        end else begin
          status_c = ST_POPPED;
          rd_calc  = rd_inc;
          data_c   = q_entry[31:0];
          pextra_c = q_entry[63:32];
          codec_c  = q_entry[35:32];
        end
      end
      default: begin
        status_c = ST_SENT;
      end
    endcase
  end

  // queue read is addressed ahead, at the entry that the next pop takes
  assign rd_next = adv ? rd_calc : rd_r;
  assign raddr   = (rd_next == U_LAST) ? '0 : rd_next + UW'(1);
  assign ram_we  = adv && push;

  cct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (UNSOL_DEPTH_P)
  ) u_unsol_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_inc),
    .wdata ({ext_r, resp_r}),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    byp_data_r <= {ext_r, resp_r};
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= ram_we && (wr_inc == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_op;
      cmd_r  <= in_command;
      rdp_r  <= in_ring_read_pointer;
      resp_r <= in_response_word;
      ext_r  <= in_response_extra;
    end
    if (adv) begin
      status_r <= status_c;
      slot_r   <= slot_c;
      codec_r  <= codec_c;
      pslot_r  <= pslot_c;
      data_r   <= data_c;
      pextra_r <= pextra_c;
      ovf_r    <= ovf_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      wp_r    <= '0;
      rd_r    <= '0;
      wr_r    <= '0;
      for (int i = 0; i < NUM_CODECS; i++) begin
        pcnt_r[i] <= '0;
        pmod_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (adv) begin
        wp_r <= wp_calc;
        rd_r <= rd_calc;
        wr_r <= wr_calc;
        if (pwe) begin
          pcnt_r[pidx] <= pcnt_new;
          pmod_r[pidx] <= pmod_new;
        end
      end
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = status_r;
  assign out_ring_slot      = slot_r;
  assign out_codec          = codec_r;
  assign out_pending_slot   = pslot_r;
  assign out_data           = data_r;
  assign out_popped_extra   = pextra_r;
  assign out_queue_overflow = ovf_r;

endmodule

`default_nettype wire

// ----- sv/cct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the codec command/response tracker top level.
`timescale 1ns / 100ps

module testbench;
  import cct_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int TIMEOUT_CYCLES  = 2_000_000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RANDOM_REQUESTS = 820;
  localparam int SATURATE_SENDS  = 520;
  localparam int FLOOD_PUSHES    = 70;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  ring_slot;
    logic [3:0]  codec;
    logic [7:0]  pending_slot;
    logic [31:0] data;
    logic [31:0] popped_extra;
    logic        queue_overflow;
  } tracker_result_t;

  class verb_tracker;
    int              ring_wp;
    logic [8:0]      pending [NUM_CODECS];
    logic [63:0]     unsol_ring [UNSOL_DEPTH];
    int              unsol_rd;
    int              unsol_wr;
    tracker_result_t due_results [$];
    int              fails;
    int              requests;
    int              overflows;
    int              by_status [9];

    function new();
      ring_wp   = 0;
      unsol_rd  = 0;
      unsol_wr  = 0;
      fails     = 0;
      requests  = 0;
      overflows = 0;
      foreach (pending[i]) pending[i] = '0;
      foreach (unsol_ring[i]) unsol_ring[i] = '0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void accept_request(logic [1:0] op, logic [31:0] cmd, logic [7:0] rp,
                                 logic [31:0] rw, logic [31:0] rx);
      tracker_result_t r;
      int              wp_next;
      int              idx;
      logic [3:0]      addr;
      logic [8:0]      cnt;
      r = '0;
      case (op)
        OP_SEND: begin
          addr    = cmd[CODEC_SHIFT +: 4];
          r.codec = addr;
          wp_next = (ring_wp + 1) % RING_ENTRIES;
          if (wp_next == int'(rp)) begin
            r.status = ST_FULL;
          end else begin
            cnt            = pending[addr];
            r.pending_slot = 8'((int'(cnt) % RING_ENTRIES));
            if (cnt < COUNT_MAX) pending[addr] = cnt + 9'd1;
            ring_wp     = wp_next;
            r.ring_slot = 8'(wp_next);
            r.data      = cmd;
            r.status    = ST_SENT;
          end
        end
        OP_RESP: begin
          addr    = rx[3:0];
          r.codec = addr;
          if (int'(addr) >= CODEC_LIMIT) begin
            r.status = ST_BAD_CODEC;
          end else if (rx[UNSOL_BIT]) begin
            unsol_wr             = (unsol_wr + 1) % UNSOL_DEPTH;
            unsol_ring[unsol_wr] = {rx, rw};
            r.queue_overflow     = (unsol_wr == unsol_rd);
            r.status             = ST_UNSOL;
          end else if (pending[addr] != 0) begin
            pending[addr]  = pending[addr] - 9'd1;
            r.pending_slot = 8'((int'(pending[addr]) % RING_ENTRIES));
            r.data         = rw;
            r.status       = ST_MATCHED;
          end else begin
            r.status = ST_SPURIOUS;
          end
        end
        OP_CANCEL: begin
          addr    = cmd[CODEC_SHIFT +: 4];
          r.codec = addr;
          if (pending[addr] != 0) pending[addr] = pending[addr] - 9'd1;
          r.status = ST_CANCELLED;
        end
        default: begin
          if (unsol_rd == unsol_wr) begin
            r.status = ST_EMPTY;
          end else begin
            idx            = (unsol_rd + 1) % UNSOL_DEPTH;
            unsol_rd       = idx;
            r.data         = unsol_ring[idx][31:0];
            r.popped_extra = unsol_ring[idx][63:32];
            r.codec        = unsol_ring[idx][35:32];
            r.status       = ST_POPPED;
          end
        end
      endcase
      requests++;
      if (r.queue_overflow) overflows++;
      by_status[r.status]++;
      due_results.push_back(r);
    endfunction

    function void take_result(tracker_result_t got);
      tracker_result_t exp;
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= REPORT_LIMIT)
          $display("unexpected result with nothing outstanding: status %0d data %h",
                   got.status, got.data);
        return;
      end
      exp = due_results.pop_front();
      if (got.status !== exp.status || got.ring_slot !== exp.ring_slot ||
          got.codec !== exp.codec || got.pending_slot !== exp.pending_slot ||
          got.data !== exp.data || got.popped_extra !== exp.popped_extra ||
          got.queue_overflow !== exp.queue_overflow) begin
        fails++;
        if (fails <= REPORT_LIMIT) begin
          $display("mismatch %0d (exp/got): status %0d/%0d ring_slot %h/%h codec %h/%h",
                   fails, exp.status, got.status, exp.ring_slot, got.ring_slot,
                   exp.codec, got.codec);
          $display("  pending_slot %h/%h data %h/%h popped_extra %h/%h overflow %b/%b",
                   exp.pending_slot, got.pending_slot, exp.data, got.data,
                   exp.popped_extra, got.popped_extra, exp.queue_overflow,
                   got.queue_overflow);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [31:0] in_command;
  logic [7:0]  in_ring_read_pointer;
  logic [31:0] in_response_word;
  logic [31:0] in_response_extra;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_status;
  logic [7:0]  out_ring_slot;
  logic [3:0]  out_codec;
  logic [7:0]  out_pending_slot;
  logic [31:0] out_data;
  logic [31:0] out_popped_extra;
  logic        out_queue_overflow;

  verb_tracker tracker;
  bit          steady;

  codec_command_response_tracker_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_command          (in_command),
    .in_ring_read_pointer(in_ring_read_pointer),
    .in_response_word    (in_response_word),
    .in_response_extra   (in_response_extra),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_ring_slot       (out_ring_slot),
    .out_codec           (out_codec),
    .out_pending_slot    (out_pending_slot),
    .out_data            (out_data),
    .out_popped_extra    (out_popped_extra),
    .out_queue_overflow  (out_queue_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", tracker.due_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_request(input logic [1:0] op, input logic [31:0] cmd,
                              input logic [7:0] rp, input logic [31:0] rw,
                              input logic [31:0] rx);
    int idle;
    in_valid             <= 1'b1;
    in_op                <= op;
    in_command           <= cmd;
    in_ring_read_pointer <= rp;
    in_response_word     <= rw;
    in_response_extra    <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.accept_request(op, cmd, rp, rw, rx);
    idle = pick_gap();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic random_request();
    logic [1:0]  op;
    logic [31:0] cmd;
    logic [7:0]  rp;
    logic [31:0] rw;
    logic [31:0] rx;
    int          pick;
    cmd  = $urandom();
    rp   = 8'($urandom());
    rw   = $urandom();
    rx   = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_SEND;
    else if (pick < 70) op = OP_RESP;
    else if (pick < 80) op = OP_CANCEL;
    else op = OP_POP;
    if (op == OP_SEND || op == OP_CANCEL) begin
      if ($urandom_range(0, 4) != 0)
        cmd[CODEC_SHIFT +: 4] = 4'($urandom_range(0, CODEC_LIMIT - 1));
      if (op == OP_SEND && $urandom_range(0, 9) == 0)
        rp = 8'((tracker.ring_wp + 1) % RING_ENTRIES);
    end
    if (op == OP_RESP) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        rx[3:0] = 4'($urandom_range(CODEC_LIMIT, 15));
      end else begin
        rx[3:0]       = 4'($urandom_range(0, CODEC_LIMIT - 1));
        rx[UNSOL_BIT] = (pick < 45);
      end
    end
    push_request(op, cmd, rp, rw, rx);
  endtask

  // result side: random backpressure, check on every handshake
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready)
        tracker.take_result({out_status, out_ring_slot, out_codec, out_pending_slot,
                             out_data, out_popped_extra, out_queue_overflow});
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    int n;
    tracker              = new();
    steady               = 1'b0;
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_op                <= OP_SEND;
    in_command           <= '0;
    in_ring_read_pointer <= '0;
    in_response_word     <= '0;
    in_response_extra    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue, spurious, bad codec, field extremes, ring full
    push_request(OP_POP,    '0,           8'h00, '0,           '0);
    push_request(OP_RESP,   '0,           8'h00, 32'h1234_5678, 32'h0000_0002);
    push_request(OP_RESP,   '0,           8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(OP_RESP,   '0,           8'h00, 32'h0000_0001, 32'h0000_0018);
    push_request(OP_SEND,   32'h0000_0000, 8'hFF, '0,           '0);
    push_request(OP_SEND,   32'hFFFF_FFFF, 8'h00, '0,           '0);
    push_request(OP_SEND,   32'h7ABC_DEF0, 8'h80, '0,           '0);
    push_request(OP_SEND,   32'h3000_0001, 8'((tracker.ring_wp + 1) % RING_ENTRIES), '0, '0);
    push_request(OP_RESP,   '0,           8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFE7);
    push_request(OP_RESP,   '0,           8'h00, 32'h0000_0000, 32'h0000_0000);
    push_request(OP_CANCEL, 32'hF000_0000, 8'h00, '0,           '0);
    push_request(OP_CANCEL, 32'hF000_0000, 8'h00, '0,           '0);
    push_request(OP_RESP,   '0,           8'h00, 32'hDEAD_BEEF, 32'h0000_0015);
    push_request(OP_RESP,   '0,           8'h00, 32'h0000_0000, 32'hFFFF_FFF0);
    push_request(OP_POP,    '0,           8'h00, '0,           '0);
    push_request(OP_POP,    '0,           8'h00, '0,           '0);
    push_request(OP_POP,    '0,           8'h00, '0,           '0);

    // drive one codec's pending count into saturation, wrapping the ring
    for (n = 0; n < SATURATE_SENDS; n++)
      push_request(OP_SEND, {4'd6, 28'($urandom())},
                   8'((tracker.ring_wp + 129) % RING_ENTRIES), '0, '0);
    for (n = 0; n < 6; n++)
      push_request(OP_RESP, '0, 8'h00, $urandom(), 32'h0000_0006);
    for (n = 0; n < 4; n++)
      push_request(OP_CANCEL, 32'h6000_0000, 8'h00, '0, '0);

    // flood the unsolicited queue past its depth, then drain it
    for (n = 0; n < FLOOD_PUSHES; n++)
      push_request(OP_RESP, '0, 8'h00, $urandom(),
                   {27'($urandom()), 1'b1, 4'($urandom_range(0, CODEC_LIMIT - 1))});
    while (tracker.unsol_rd != tracker.unsol_wr)
      push_request(OP_POP, $urandom(), 8'($urandom()), $urandom(), $urandom());
    push_request(OP_POP, '0, 8'h00, '0, '0);

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 200 == 0) steady = ($urandom_range(0, 3) == 0);
      random_request();
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d sent, %0d ring full, %0d bad codec, %0d matched, %0d spurious",
             tracker.requests, tracker.by_status[ST_SENT], tracker.by_status[ST_FULL],
             tracker.by_status[ST_BAD_CODEC], tracker.by_status[ST_MATCHED],
             tracker.by_status[ST_SPURIOUS]);
    $display("%0d unsolicited (%0d overflows), %0d popped, %0d empty pops, %0d cancels",
             tracker.by_status[ST_UNSOL], tracker.overflows, tracker.by_status[ST_POPPED],
             tracker.by_status[ST_EMPTY], tracker.by_status[ST_CANCELLED]);
    if (tracker.fails == 0 && tracker.due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
